// ===== design/alu8f_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package alu8f_pkg;

  localparam int unsigned OpcodeWidth = 4;
  localparam int unsigned ByteWidth   = 8;
  localparam int unsigned NibbleWidth = 4;

  typedef enum logic [OpcodeWidth-1:0] {
    OP_ADD = 4'd0,
    OP_ADC = 4'd1,
    OP_SUB = 4'd2,
    OP_SBC = 4'd3,
    OP_CP  = 4'd4,
    OP_AND = 4'd5,
    OP_OR  = 4'd6,
    OP_XOR = 4'd7,
    OP_INC = 4'd8,
    OP_DEC = 4'd9
  } opcode_e;

  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  localparam flags_t FlagsReset = '0;

  typedef struct packed {
    logic [OpcodeWidth-1:0] opcode;
    logic [ByteWidth-1:0]   operand_a;
    logic [ByteWidth-1:0]   operand_b;
  } in_beat_t;

  typedef struct packed {
    logic [ByteWidth-1:0] result_byte;
    logic                 zero_flag;
    logic                 subtract_flag;
    logic                 half_carry_flag;
    logic                 carry_flag;
  } out_beat_t;

  // Handshake between the input register and the output stage.
  typedef struct packed {
    logic advance;
  } stage_ctrl_t;

endpackage

`default_nettype wire

// ===== design/alu8f_stream_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface alu8f_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (
    output valid,
    output payload,
    input  ready
  );

  modport sink (
    input  valid,
    input  payload,
    output ready
  );

endinterface

`default_nettype wire

// ===== design/alu8f_in_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module alu8f_in_reg (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  alu8f_stream_if.sink               in_i,
  input  wire logic                  advance_i,
  output logic                       valid_o,
  output alu8f_pkg::in_beat_t        beat_o
);

  logic                valid_q, valid_d;
  alu8f_pkg::in_beat_t beat_q;
  logic                take;

  assign in_i.ready = !valid_q || advance_i;
  assign take       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      beat_q <= in_i.payload;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

`default_nettype wire

// ===== design/alu8f_exec.sv =====
`timescale 1ns / 1ps
`default_nettype none

module alu8f_exec (
  input  wire alu8f_pkg::in_beat_t beat_i,
  input  wire alu8f_pkg::flags_t   flags_i,
  output logic [alu8f_pkg::ByteWidth-1:0] result_o,
  output alu8f_pkg::flags_t   flags_o
);

  localparam int unsigned BW = alu8f_pkg::ByteWidth;
  localparam int unsigned NW = alu8f_pkg::NibbleWidth;

  alu8f_pkg::opcode_e op;
  logic [BW-1:0]      a, b;
  logic               cin;
  logic [BW:0]        sum_w, diff_w;
  logic [NW:0]        hsum_w, hdiff_w;
  logic [BW-1:0]      inc_w, dec_w;
  logic               is_zero_sum, is_zero_diff;

  assign op = alu8f_pkg::opcode_e'(beat_i.opcode);
  assign a  = beat_i.operand_a;
  assign b  = beat_i.operand_b;

  assign cin = ((op == alu8f_pkg::OP_ADC) || (op == alu8f_pkg::OP_SBC)) ? flags_i.c : 1'b0;

  assign sum_w   = {1'b0, a} + {1'b0, b} + {{BW{1'b0}}, cin};
  assign diff_w  = {1'b0, a} - {1'b0, b} - {{BW{1'b0}}, cin};
  assign hsum_w  = {1'b0, a[NW-1:0]} + {1'b0, b[NW-1:0]} + {{NW{1'b0}}, cin};
  assign hdiff_w = {1'b0, a[NW-1:0]} - {1'b0, b[NW-1:0]} - {{NW{1'b0}}, cin};
  assign inc_w   = a + {{(BW-1){1'b0}}, 1'b1};
  assign dec_w   = a - {{(BW-1){1'b0}}, 1'b1};

  assign is_zero_sum  = (sum_w[BW-1:0] == '0);
  assign is_zero_diff = (diff_w[BW-1:0] == '0);

  always_comb begin
    result_o = a;
    flags_o  = flags_i;
    unique case (op)
      alu8f_pkg::OP_ADD,
      alu8f_pkg::OP_ADC: begin
        result_o = sum_w[BW-1:0];
        flags_o  = '{z: is_zero_sum, n: 1'b0, h: hsum_w[NW], c: sum_w[BW]};
      end
      alu8f_pkg::OP_SUB,
      alu8f_pkg::OP_SBC: begin
        result_o = diff_w[BW-1:0];
        flags_o  = '{z: is_zero_diff, n: 1'b1, h: hdiff_w[NW], c: diff_w[BW]};
      end
      alu8f_pkg::OP_CP: begin
        result_o = a;
        flags_o  = '{z: is_zero_diff, n: 1'b1, h: hdiff_w[NW], c: diff_w[BW]};
      end
      alu8f_pkg::OP_AND: begin
        result_o = a & b;
        flags_o  = '{z: ((a & b) == '0), n: 1'b0, h: 1'b1, c: 1'b0};
      end
      alu8f_pkg::OP_OR: begin
        result_o = a | b;
        flags_o  = '{z: ((a | b) == '0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      alu8f_pkg::OP_XOR: begin
        result_o = a ^ b;
        flags_o  = '{z: ((a ^ b) == '0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      alu8f_pkg::OP_INC: begin
        result_o = inc_w;
        flags_o  = '{z: (inc_w == '0), n: 1'b0, h: (a[NW-1:0] == '1), c: flags_i.c};
      end
      alu8f_pkg::OP_DEC: begin
        result_o = dec_w;
        flags_o  = '{z: (dec_w == '0), n: 1'b1, h: (a[NW-1:0] == '0), c: flags_i.c};
      end
      default: begin
        // undefined opcode: pass operand A, keep flags
        result_o = a;
        flags_o  = flags_i;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/alu8f_out_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module alu8f_out_reg (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  input  wire logic [alu8f_pkg::ByteWidth-1:0] result_i,
  input  wire alu8f_pkg::flags_t           flags_i,
  output alu8f_pkg::flags_t                flags_o,
  output alu8f_pkg::stage_ctrl_t           ctrl_o,
  alu8f_stream_if.source                   out_o
);

  logic                 valid_q, valid_d;
  logic                 advance;
  alu8f_pkg::out_beat_t beat_q;
  alu8f_pkg::flags_t    flags_q;

  assign advance = valid_i && (!valid_q || out_o.ready);

  always_comb begin
    valid_d = valid_q;
    if (advance) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      flags_q <= alu8f_pkg::FlagsReset;
    end else begin
      valid_q <= valid_d;
      if (advance) begin
        flags_q <= flags_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      beat_q <= '{result_byte:     result_i,
                  zero_flag:       flags_i.z,
                  subtract_flag:   flags_i.n,
                  half_carry_flag: flags_i.h,
                  carry_flag:      flags_i.c};
    end
  end

  assign out_o.valid    = valid_q;
  assign out_o.payload  = beat_q;
  assign flags_o        = flags_q;
  assign ctrl_o.advance = advance;

endmodule

`default_nettype wire

// ===== design/alu8_with_flags.sv =====
// channel | dir | payload                                              | beat
// in_i    | in  | opcode, operand_a, operand_b                         | one operation
// out_o   | out | result_byte, zero/subtract/half_carry/carry flags    | one result
//
// From input beat to result beat: input register, ALU, result register.
// One beat per cycle is sustained while out_o is ready; the kept flags update as a
// result enters the result register, so the next operation sees them with no bubble.
// Reset clears both stage valids and the flag register.
// A stalled result holds its register; the input register still takes a beat
// whenever it is empty or moving forward.
`timescale 1ns / 1ps
`default_nettype none

module alu8_with_flags (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  alu8f_stream_if.sink   in_i,
  alu8f_stream_if.source out_o
);

  logic                                s1_valid;
  alu8f_pkg::in_beat_t                 s1_beat;
  logic [alu8f_pkg::ByteWidth-1:0]     exec_result;
  alu8f_pkg::flags_t                   exec_flags;
  alu8f_pkg::flags_t                   flags_q;
  alu8f_pkg::stage_ctrl_t              out_ctrl;

  alu8f_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (out_ctrl.advance),
    .valid_o   (s1_valid),
    .beat_o    (s1_beat)
  );

  alu8f_exec u_exec (
    .beat_i   (s1_beat),
    .flags_i  (flags_q),
    .result_o (exec_result),
    .flags_o  (exec_flags)
  );

  alu8f_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s1_valid),
    .result_i (exec_result),
    .flags_i  (exec_flags),
    .flags_o  (flags_q),
    .ctrl_o   (out_ctrl),
    .out_o    (out_o)
  );

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned UnusedOpFirst   = int'(alu8f_pkg::OP_DEC) + 1;
  localparam int unsigned UnusedOpLast    = (1 << alu8f_pkg::OpcodeWidth) - 1;
  localparam int unsigned LongStallCycles = 150;
  localparam int unsigned QuietLimit      = 1000;
  localparam int unsigned DrainSlack      = 8;

  class alu_result_ledger;
    alu8f_pkg::flags_t    held_flags;
    alu8f_pkg::out_beat_t awaited[$];
    int unsigned          mismatches;

    function new();
      held_flags = alu8f_pkg::FlagsReset;
      mismatches = 0;
    endfunction

    function alu8f_pkg::out_beat_t predict_result(alu8f_pkg::in_beat_t beat);
      logic [alu8f_pkg::ByteWidth-1:0]   a;
      logic [alu8f_pkg::ByteWidth-1:0]   b;
      logic [alu8f_pkg::ByteWidth-1:0]   res;
      logic [alu8f_pkg::ByteWidth:0]     wide;
      logic [alu8f_pkg::NibbleWidth:0]   nib;
      logic                              cin;
      alu8f_pkg::flags_t                 f;
      alu8f_pkg::out_beat_t              r;
      a   = beat.operand_a;
      b   = beat.operand_b;
      res = a;
      f   = held_flags;
      cin = 1'b0;
      case (beat.opcode)
        alu8f_pkg::OP_ADD, alu8f_pkg::OP_ADC: begin
          if (beat.opcode == alu8f_pkg::OP_ADC) cin = held_flags.c;
          wide = {1'b0, a} + {1'b0, b} + {{alu8f_pkg::ByteWidth{1'b0}}, cin};
          nib  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {{alu8f_pkg::NibbleWidth{1'b0}}, cin};
          res  = wide[alu8f_pkg::ByteWidth-1:0];
          f.z  = (res == '0);
          f.n  = 1'b0;
          f.h  = nib[alu8f_pkg::NibbleWidth];
          f.c  = wide[alu8f_pkg::ByteWidth];
        end
        alu8f_pkg::OP_SUB, alu8f_pkg::OP_SBC, alu8f_pkg::OP_CP: begin
          if (beat.opcode == alu8f_pkg::OP_SBC) cin = held_flags.c;
          wide = {1'b0, a} - {1'b0, b} - {{alu8f_pkg::ByteWidth{1'b0}}, cin};
          nib  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {{alu8f_pkg::NibbleWidth{1'b0}}, cin};
          f.z  = (wide[alu8f_pkg::ByteWidth-1:0] == '0);
          f.n  = 1'b1;
          f.h  = nib[alu8f_pkg::NibbleWidth];
          f.c  = wide[alu8f_pkg::ByteWidth];
          res  = (beat.opcode == alu8f_pkg::OP_CP) ? a : wide[alu8f_pkg::ByteWidth-1:0];
        end
        alu8f_pkg::OP_AND: begin
          res = a & b;
          f.z = (res == '0);
          f.n = 1'b0;
          f.h = 1'b1;
          f.c = 1'b0;
        end
        alu8f_pkg::OP_OR, alu8f_pkg::OP_XOR: begin
          res = (beat.opcode == alu8f_pkg::OP_OR) ? (a | b) : (a ^ b);
          f.z = (res == '0);
          f.n = 1'b0;
          f.h = 1'b0;
          f.c = 1'b0;
        end
        alu8f_pkg::OP_INC: begin
          res = a + 8'd1;
          f.z = (res == '0);
          f.n = 1'b0;
          f.h = (a[3:0] == 4'hF);
          f.c = held_flags.c;
        end
        alu8f_pkg::OP_DEC: begin
          res = a - 8'd1;
          f.z = (res == '0);
          f.n = 1'b1;
          f.h = (a[3:0] == 4'h0);
          f.c = held_flags.c;
        end
        default: begin
        end
      endcase
      held_flags        = f;
      r.result_byte     = res;
      r.zero_flag       = f.z;
      r.subtract_flag   = f.n;
      r.half_carry_flag = f.h;
      r.carry_flag      = f.c;
      return r;
    endfunction

    function void note_operation(alu8f_pkg::in_beat_t beat);
      awaited.push_back(predict_result(beat));
    endfunction

    function void compare_field(string name, logic [alu8f_pkg::ByteWidth-1:0] want,
                                logic [alu8f_pkg::ByteWidth-1:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(alu8f_pkg::out_beat_t got);
      alu8f_pkg::out_beat_t want;
      if (awaited.size() == 0) begin
        $display("%0t: result %0h arrived with none awaited", $time, got);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      compare_field("result_byte", want.result_byte, got.result_byte);
      compare_field("zero_flag", alu8f_pkg::ByteWidth'(want.zero_flag),
                    alu8f_pkg::ByteWidth'(got.zero_flag));
      compare_field("subtract_flag", alu8f_pkg::ByteWidth'(want.subtract_flag),
                    alu8f_pkg::ByteWidth'(got.subtract_flag));
      compare_field("half_carry_flag", alu8f_pkg::ByteWidth'(want.half_carry_flag),
                    alu8f_pkg::ByteWidth'(got.half_carry_flag));
      compare_field("carry_flag", alu8f_pkg::ByteWidth'(want.carry_flag),
                    alu8f_pkg::ByteWidth'(got.carry_flag));
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  alu8f_stream_if #(.payload_t(alu8f_pkg::in_beat_t))  in_ch ();
  alu8f_stream_if #(.payload_t(alu8f_pkg::out_beat_t)) out_ch ();

  alu8_with_flags dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  alu_result_ledger book;
  int unsigned      send_idle_pct = 7;
  int unsigned      recv_idle_pct = 71;
  bit               long_stall_req = 1'b0;
  int unsigned      quiet_cycles = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // receiver: random backpressure, plus one long hold on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LongStallCycles) @(negedge clk_i);
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) book.note_operation(in_ch.payload);
      if (out_ch.valid && out_ch.ready) book.check_result(out_ch.payload);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: watchdog expired", $time);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic send_beat(input alu8f_pkg::in_beat_t beat);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= beat;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic send_op(input logic [alu8f_pkg::OpcodeWidth-1:0] op,
                         input logic [alu8f_pkg::ByteWidth-1:0] a,
                         input logic [alu8f_pkg::ByteWidth-1:0] b);
    alu8f_pkg::in_beat_t beat;
    beat.opcode    = op;
    beat.operand_a = a;
    beat.operand_b = b;
    send_beat(beat);
  endtask

  function automatic logic [alu8f_pkg::ByteWidth-1:0] pick_byte();
    logic [alu8f_pkg::ByteWidth-1:0] corner_bytes[8];
    corner_bytes = '{8'h00, 8'h01, 8'h0F, 8'h10, 8'h7F, 8'h80, 8'hF0, 8'hFF};
    if ($urandom_range(99) < 20) return corner_bytes[$urandom_range(7)];
    return alu8f_pkg::ByteWidth'($urandom);
  endfunction

  task automatic send_random(input int unsigned count);
    alu8f_pkg::in_beat_t beat;
    repeat (count) begin
      if ($urandom_range(99) < 88) begin
        beat.opcode = alu8f_pkg::OpcodeWidth'($urandom_range(alu8f_pkg::OP_DEC,
                                                             alu8f_pkg::OP_ADD));
      end else begin
        beat.opcode = alu8f_pkg::OpcodeWidth'($urandom_range(UnusedOpLast, UnusedOpFirst));
      end
      beat.operand_a = pick_byte();
      beat.operand_b = pick_byte();
      send_beat(beat);
    end
  endtask

  // drop valid and hold until every result is back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (book.pending() != 0) @(negedge clk_i);
  endtask

  task automatic send_directed();
    send_op(alu8f_pkg::OP_ADD, 8'h00, 8'h00);
    send_op(alu8f_pkg::OP_ADD, 8'hFF, 8'h01);
    send_op(alu8f_pkg::OP_ADD, 8'h0F, 8'h01);
    send_op(alu8f_pkg::OP_ADD, 8'h80, 8'h80);
    send_op(alu8f_pkg::OP_ADC, 8'hFF, 8'hFF);
    send_op(alu8f_pkg::OP_ADC, 8'h0F, 8'h00);
    send_op(alu8f_pkg::OP_SUB, 8'h42, 8'h42);
    send_op(alu8f_pkg::OP_SUB, 8'h00, 8'h01);
    send_op(alu8f_pkg::OP_SBC, 8'h00, 8'hFF);
    send_op(alu8f_pkg::OP_SBC, 8'h10, 8'h0F);
    send_op(alu8f_pkg::OP_SUB, 8'h10, 8'h01);
    send_op(alu8f_pkg::OP_CP, 8'h3C, 8'h3C);
    send_op(alu8f_pkg::OP_CP, 8'h01, 8'h02);
    send_op(alu8f_pkg::OP_INC, 8'hFF, 8'hA5);
    send_op(alu8f_pkg::OP_INC, 8'h0F, 8'h00);
    send_op(alu8f_pkg::OP_DEC, 8'h01, 8'hFF);
    send_op(alu8f_pkg::OP_DEC, 8'h00, 8'h00);
    send_op(alu8f_pkg::OP_DEC, 8'h10, 8'h5A);
    send_op(alu8f_pkg::OP_AND, 8'hFF, 8'hFF);
    send_op(alu8f_pkg::OP_AND, 8'hF0, 8'h0F);
    send_op(alu8f_pkg::OP_OR, 8'h00, 8'h00);
    send_op(alu8f_pkg::OP_OR, 8'hF0, 8'h0F);
    send_op(alu8f_pkg::OP_XOR, 8'hFF, 8'hFF);
    send_op(alu8f_pkg::OP_XOR, 8'hAA, 8'h55);
    send_op(alu8f_pkg::OpcodeWidth'(UnusedOpFirst), 8'h12, 8'h34);
    send_op(alu8f_pkg::OpcodeWidth'(UnusedOpLast), 8'hFF, 8'h00);
  endtask

  initial begin
    book          = new();
    rst_ni        = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    send_directed();
    send_random(300);
    long_stall_req = 1'b1;
    send_random(300);
    wait_drained();

    send_idle_pct = 71;
    recv_idle_pct = 7;
    send_random(600);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(625);

    wait_drained();
    repeat (DrainSlack) @(negedge clk_i);
    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/alu8f_pkg.sv
design/alu8f_stream_if.sv
design/alu8f_in_reg.sv
design/alu8f_exec.sv
design/alu8f_out_reg.sv
design/alu8_with_flags.sv
bench/testbench.sv
